// File: hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants of the 3x3 matrix inverse
// Widths of elements, cofactors, determinant and quotients, and the word
// type that the front part hands to the divider through the queue.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int ELW  = 16;       // matrix element width
    localparam int OUTW = 32;       // result element width
    localparam int CW   = 33;       // signed cofactor width
    localparam int TW   = ELW + CW; // signed determinant term width
    localparam int DETW = TW + 2;   // signed determinant width
    localparam int NMW  = CW;       // cofactor magnitude width
    localparam int DMW  = DETW;     // determinant magnitude width
    localparam int QB   = 33;       // quotient bits kept before saturation
    localparam int LANES = 9;

    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // One classified matrix: lane l is output element l (row-major) and
    // holds the magnitude of the transposed cofactor and the quotient sign.
    typedef struct packed {
        logic                            sing;
        logic [DMW-1:0]                  dmag;
        logic [LANES-1:0][NMW-1:0]       nmag;
        logic [LANES-1:0]                qneg;
    } m3i_cls_t;

endpackage

// File: hdl/m3i_mat_if.sv
// ----------------------------------------------------------------------------
// m3i_mat_if: matrix channel
// Carries one 3x3 matrix of signed elements per word.
// ----------------------------------------------------------------------------
interface m3i_mat_if;
    logic valid;
    logic ready;
    logic signed [m3i_pkg::ELW-1:0] a_00;
    logic signed [m3i_pkg::ELW-1:0] a_01;
    logic signed [m3i_pkg::ELW-1:0] a_02;
    logic signed [m3i_pkg::ELW-1:0] a_10;
    logic signed [m3i_pkg::ELW-1:0] a_11;
    logic signed [m3i_pkg::ELW-1:0] a_12;
    logic signed [m3i_pkg::ELW-1:0] a_20;
    logic signed [m3i_pkg::ELW-1:0] a_21;
    logic signed [m3i_pkg::ELW-1:0] a_22;

    modport source (output valid, a_00, a_01, a_02, a_10, a_11, a_12,
                    a_20, a_21, a_22, input ready);
    modport sink   (input valid, a_00, a_01, a_02, a_10, a_11, a_12,
                    a_20, a_21, a_22, output ready);
endinterface

// File: hdl/m3i_inv_if.sv
// ----------------------------------------------------------------------------
// m3i_inv_if: inverse channel
// Carries one inverse matrix with its singular and saturated flags per word.
// ----------------------------------------------------------------------------
interface m3i_inv_if;
    logic valid;
    logic ready;
    logic signed [m3i_pkg::OUTW-1:0] inv_00;
    logic signed [m3i_pkg::OUTW-1:0] inv_01;
    logic signed [m3i_pkg::OUTW-1:0] inv_02;
    logic signed [m3i_pkg::OUTW-1:0] inv_10;
    logic signed [m3i_pkg::OUTW-1:0] inv_11;
    logic signed [m3i_pkg::OUTW-1:0] inv_12;
    logic signed [m3i_pkg::OUTW-1:0] inv_20;
    logic signed [m3i_pkg::OUTW-1:0] inv_21;
    logic signed [m3i_pkg::OUTW-1:0] inv_22;
    logic singular;
    logic saturated;

    modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11,
                    inv_12, inv_20, inv_21, inv_22, singular, saturated,
                    input ready);
    modport sink   (input valid, inv_00, inv_01, inv_02, inv_10, inv_11,
                    inv_12, inv_20, inv_21, inv_22, singular, saturated,
                    output ready);
endinterface

// File: hdl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front: cofactors, determinant and classification
// Three pipeline stages: cofactors, determinant terms, then the determinant
// sum with the magnitudes and signs that the divider needs.
// ----------------------------------------------------------------------------
module m3i_front (
    input  logic              clk,
    input  logic              rst_n,
    m3i_mat_if.sink           mat,
    output logic              cls_valid,
    output m3i_pkg::m3i_cls_t cls,
    input  logic              cls_ready
);

    localparam int ELW  = m3i_pkg::ELW;
    localparam int CW   = m3i_pkg::CW;
    localparam int TW   = m3i_pkg::TW;
    localparam int DETW = m3i_pkg::DETW;

    logic en;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [ELW-1:0] m [3][3];
    logic signed [CW-1:0]  cof_next [3][3];
    logic signed [CW-1:0]  cof1_reg [3][3];
    logic signed [ELW-1:0] row1_reg [3];
    logic signed [CW-1:0]  cof2_reg [3][3];
    logic signed [TW-1:0]  term_next [3];
    logic signed [TW-1:0]  term2_reg [3];
    logic signed [DETW-1:0] det;
    m3i_pkg::m3i_cls_t     cls_next;
    m3i_pkg::m3i_cls_t     cls_reg;

    assign en        = cls_ready || !v3_reg;
    assign mat.ready = en;
    assign cls_valid = v3_reg;
    assign cls       = cls_reg;

    assign m[0][0] = mat.a_00;
    assign m[0][1] = mat.a_01;
    assign m[0][2] = mat.a_02;
    assign m[1][0] = mat.a_10;
    assign m[1][1] = mat.a_11;
    assign m[1][2] = mat.a_12;
    assign m[2][0] = mat.a_20;
    assign m[2][1] = mat.a_21;
    assign m[2][2] = mat.a_22;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cof_next[i][j] = CW'(m[(i+1)%3][(j+1)%3]) * CW'(m[(i+2)%3][(j+2)%3])
                               - CW'(m[(i+1)%3][(j+2)%3]) * CW'(m[(i+2)%3][(j+1)%3]);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            term_next[j] = TW'(row1_reg[j]) * TW'(cof1_reg[0][j]);
        end
    end

    always_comb
    begin
        det = DETW'(term2_reg[0]) + DETW'(term2_reg[1]) + DETW'(term2_reg[2]);
        cls_next.sing = (det == '0);
        cls_next.dmag = det[DETW-1] ? DETW'(-det) : DETW'(det);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // Output element (i, j) takes cofactor (j, i).
                cls_next.nmag[i*3+j] = cof2_reg[j][i][CW-1] ? CW'(-cof2_reg[j][i])
                                                            : CW'(cof2_reg[j][i]);
                cls_next.qneg[i*3+j] = cof2_reg[j][i][CW-1] ^ det[DETW-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= mat.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof1_reg  <= cof_next;
            row1_reg  <= m[0];
            cof2_reg  <= cof1_reg;
            term2_reg <= term_next;
            cls_reg   <= cls_next;
        end
    end

endmodule

// File: hdl/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue: two-entry queue between front and divider
// Lets the front keep accepting words while the divider is stalled.
// ----------------------------------------------------------------------------
module m3i_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  m3i_pkg::m3i_cls_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    output m3i_pkg::m3i_cls_t pop_data,
    input  logic              pop_ready
);

    m3i_pkg::m3i_cls_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back: pipelined restoring divider, nine lanes
// One quotient bit per stage for every lane, then saturation to the output
// format in a final stage that is also the output register.
// ----------------------------------------------------------------------------
module m3i_back #(
    parameter int IN_FRAC_BITS  = m3i_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = m3i_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cls_valid,
    input  m3i_pkg::m3i_cls_t cls,
    output logic              cls_ready,
    m3i_inv_if.source         res
);

    localparam int SH    = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int NMW   = m3i_pkg::NMW;
    localparam int DMW   = m3i_pkg::DMW;
    localparam int QB    = m3i_pkg::QB;
    localparam int OUTW  = m3i_pkg::OUTW;
    localparam int LANES = m3i_pkg::LANES;
    localparam int XW    = (NMW + SH > DMW + QB) ? NMW + SH : DMW + QB;

    logic en;
    logic vld_reg [QB+2];

    logic [XW-1:0]  rem_reg  [QB+1][LANES];
    logic [QB-1:0]  quo_reg  [QB+1][LANES];
    logic           neg_reg  [QB+1][LANES];
    logic           ovf_reg  [QB+1][LANES];
    logic [DMW-1:0] dmag_reg [QB+1];
    logic           sing_reg [QB+1];

    logic [XW-1:0]  rem_next [QB+1][LANES];
    logic [QB-1:0]  quo_next [QB+1][LANES];
    logic           ovf_next [QB+1][LANES];

    logic [OUTW-1:0] out_next [LANES];
    logic            sat_next;
    logic [OUTW-1:0] out_reg  [LANES];
    logic            sing_out_reg, sat_out_reg;

    assign en        = res.ready || !vld_reg[QB+1];
    assign cls_ready = en;

    always_comb
    begin
        logic [XW-1:0] num;
        logic [XW-1:0] dsh;
        logic [QB-1:0] q;
        for (int l = 0; l < LANES; l++)
        begin
            // Entry: quotients of 2^QB or more saturate whatever follows.
            num = XW'(cls.nmag[l]) << SH;
            dsh = XW'(cls.dmag) << QB;
            rem_next[0][l] = num;
            quo_next[0][l] = '0;
            ovf_next[0][l] = (num >= dsh);
        end
        for (int s = 1; s <= QB; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dsh = XW'(dmag_reg[s-1]) << (QB - s);
                rem_next[s][l] = rem_reg[s-1][l];
                quo_next[s][l] = quo_reg[s-1][l];
                ovf_next[s][l] = ovf_reg[s-1][l];
                if (!ovf_reg[s-1][l] && rem_reg[s-1][l] >= dsh)
                begin
                    rem_next[s][l] = rem_reg[s-1][l] - dsh;
                    quo_next[s][l][QB-s] = 1'b1;
                end
            end
        end
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            q = quo_reg[QB][l];
            if (neg_reg[QB][l])
            begin
                if (ovf_reg[QB][l] || q[QB-1] || (q[OUTW-1] && (q[OUTW-2:0] != '0)))
                begin
                    out_next[l] = {1'b1, {(OUTW-1){1'b0}}};
                    sat_next    = 1'b1;
                end
                else
                begin
                    out_next[l] = OUTW'(-q[OUTW-1:0]);
                end
            end
            else
            begin
                if (ovf_reg[QB][l] || q[QB-1] || q[OUTW-1])
                begin
                    out_next[l] = {1'b0, {(OUTW-1){1'b1}}};
                    sat_next    = 1'b1;
                end
                else
                begin
                    out_next[l] = q[OUTW-1:0];
                end
            end
            if (sing_reg[QB])
            begin
                out_next[l] = '0;
            end
        end
        if (sing_reg[QB])
        begin
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QB + 2; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= cls_valid;
            for (int s = 1; s < QB + 2; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            ovf_reg <= ovf_next;
            dmag_reg[0] <= cls.dmag;
            sing_reg[0] <= cls.sing;
            for (int l = 0; l < LANES; l++)
            begin
                neg_reg[0][l] <= cls.qneg[l];
            end
            for (int s = 1; s <= QB; s++)
            begin
                dmag_reg[s] <= dmag_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
            out_reg      <= out_next;
            sing_out_reg <= sing_reg[QB];
            sat_out_reg  <= sat_next;
        end
    end

    assign res.valid     = vld_reg[QB+1];
    assign res.inv_00    = out_reg[0];
    assign res.inv_01    = out_reg[1];
    assign res.inv_02    = out_reg[2];
    assign res.inv_10    = out_reg[3];
    assign res.inv_11    = out_reg[4];
    assign res.inv_12    = out_reg[5];
    assign res.inv_20    = out_reg[6];
    assign res.inv_21    = out_reg[7];
    assign res.inv_22    = out_reg[8];
    assign res.singular  = sing_out_reg;
    assign res.saturated = sat_out_reg;

endmodule

// File: hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 fixed-point matrix inverse by the adjugate
// An accepted matrix word passes three front stages, the storage register
// of the queue and 35 divider stages on the way to its inverse word.
// Throughput is one word per cycle while inv is ready, set by the fully
// pipelined divider: one quotient bit per stage in each of its nine lanes.
// Reset clears only the valid flags and queue pointers; data is not reset.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int IN_FRAC_BITS  = m3i_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = m3i_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    m3i_mat_if.sink   mat,
    m3i_inv_if.source inv
);

    // The front forms cofactors and the determinant and classifies each
    // word; it stalls only when the queue is full.
    logic              f_valid, f_ready;
    m3i_pkg::m3i_cls_t f_cls;

    // The back side of the queue feeds the divider, which stalls only on
    // the inverse channel.
    logic              b_valid, b_ready;
    m3i_pkg::m3i_cls_t b_cls;

    m3i_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .cls_valid (f_valid),
        .cls       (f_cls),
        .cls_ready (f_ready)
    );

    m3i_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_cls),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_data   (b_cls),
        .pop_ready  (b_ready)
    );

    // Each quotient is trunc(cofactor * 2^(IN+OUT) / det), saturated to the
    // signed 32-bit output; a zero determinant gives all zeros.
    m3i_back #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (b_valid),
        .cls       (b_cls),
        .cls_ready (b_ready),
        .res       (inv)
    );

endmodule
